[rtl/csrg_pkg.sv]
`timescale 1ns / 1ps
package csrg_pkg;

  localparam int PHASE_W    = 48;
  localparam int AMP_W      = 31;
  localparam int ASTEP_W    = 32;
  localparam int IDX_W      = 16;
  localparam int LEN_REG_W  = 17;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int PROD_W     = 2 * AMP_W;

  // Q30 constants of the quarter-wave polynomial
  localparam logic [AMP_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [AMP_W-1:0] COEF_C1 = 31'd1686629713;
  localparam logic [AMP_W-1:0] COEF_C3 = 31'd693598668;
  localparam logic [AMP_W-1:0] COEF_C5 = 31'd85569306;
  localparam logic [AMP_W-1:0] COEF_C7 = 31'd5026995;
  localparam logic [AMP_W-1:0] COEF_C9 = 31'd172273;

  localparam logic [LEN_REG_W-1:0] LEN_RESET = 17'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_START,
    REG_PHASE_STEP_START,
    REG_PHASE_STEP_SLOPE,
    REG_AMPLITUDE_START,
    REG_AMPLITUDE_STEP,
    REG_FIRST_SAMPLE,
    REG_LAST_SAMPLE,
    REG_PAXEL_LENGTH
  } csrg_reg_e;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase_start;
    logic [PHASE_W-1:0]   phase_step_start;
    logic [PHASE_W-1:0]   phase_step_slope;
    logic [AMP_W-1:0]     amplitude_start;
    logic [ASTEP_W-1:0]   amplitude_step;
    logic [IDX_W-1:0]     first_sample;
    logic [IDX_W-1:0]     last_sample;
    logic [LEN_REG_W-1:0] paxel_length;
  } csrg_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic [IDX_W-1:0]    sample_index;
    logic                last;
  } csrg_result_t;

endpackage

[rtl/csrg_fifo.sv]
`timescale 1ns / 1ps
module csrg_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (rd_en && !wr_en) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/csrg_sine.sv]
`timescale 1ns / 1ps
module csrg_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [SINE_TABLE_BITS-1:0]          idx_i,
  input  logic [csrg_pkg::AMP_W-1:0]          amp_i,
  output logic                                done_o,
  output logic signed [csrg_pkg::SAMPLE_W-1:0] sample_o
);

  import csrg_pkg::*;

  localparam int POS_W = SINE_TABLE_BITS - 2;
  localparam int SHIFT = 30 - POS_W;
  localparam logic [PROD_W:0]     RND_HALF = (PROD_W + 1)'(1) << 44;
  localparam logic [SAMPLE_W-1:0] SAT_MAX  = 16'h7FFF;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_POST} state_e;

  // Each member names the product that was just formed.
  typedef enum logic [2:0] {
    P_X2, P_T7, P_T5, P_T3, P_T1, P_S, P_MAG
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   done_q, done_d;

  logic [AMP_W-1:0]    x_q, x_d, x2_q, x2_d, amp_q, amp_d;
  logic [AMP_W-1:0]    a_q, a_d, b_q, b_d;
  logic [PROD_W-1:0]   p_q, p_d;
  logic                neg_q, neg_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;

  logic [AMP_W-1:0]    x_pos, x_in;
  logic [AMP_W:0]      s_full;
  logic [PROD_W:0]     rnd;
  logic [SAMPLE_W-1:0] mag;

  function automatic logic [AMP_W-1:0] horner(input logic [AMP_W-1:0]  coef,
                                              input logic [PROD_W-1:0] prod);
    logic [AMP_W:0] diff;
    diff = {1'b0, coef} - prod[61:30];
    return diff[AMP_W-1:0];
  endfunction

  // Fold the phase onto the first quarter turn.
  assign x_pos = {1'b0, idx_i[POS_W-1:0], {SHIFT{1'b0}}};
  assign x_in  = idx_i[SINE_TABLE_BITS-2] ? (ONE_Q30 - x_pos) : x_pos;

  assign s_full = p_q[61:30];
  assign rnd    = {1'b0, p_q} + RND_HALF;
  assign mag    = rnd[60:45];

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    done_d   = 1'b0;
    x_d      = x_q;
    x2_d     = x2_q;
    amp_d    = amp_q;
    a_d      = a_q;
    b_d      = b_q;
    p_d      = p_q;
    neg_d    = neg_q;
    sample_d = sample_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d     = x_in;
          amp_d   = amp_i;
          neg_d   = idx_i[SINE_TABLE_BITS-1];
          a_d     = x_in;
          b_d     = x_in;
          step_d  = P_X2;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        p_d     = a_q * b_q;
        state_d = S_POST;
      end
      S_POST: begin
        state_d = S_MUL;
        case (step_q)
          P_X2: begin
            x2_d   = p_q[60:30];
            a_d    = p_q[60:30];
            b_d    = COEF_C9;
            step_d = P_T7;
          end
          P_T7: begin
            a_d    = x2_q;
            b_d    = horner(COEF_C7, p_q);
            step_d = P_T5;
          end
          P_T5: begin
            a_d    = x2_q;
            b_d    = horner(COEF_C5, p_q);
            step_d = P_T3;
          end
          P_T3: begin
            a_d    = x2_q;
            b_d    = horner(COEF_C3, p_q);
            step_d = P_T1;
          end
          P_T1: begin
            a_d    = x_q;
            b_d    = horner(COEF_C1, p_q);
            step_d = P_S;
          end
          P_S: begin
            a_d    = amp_q;
            b_d    = (s_full > {1'b0, ONE_Q30}) ? ONE_Q30 : s_full[AMP_W-1:0];
            step_d = P_MAG;
          end
          P_MAG: begin
            // Apply the sign last; only the positive side saturates, since the negative side can reach full scale.
            if (neg_q) begin
              sample_d = SAMPLE_W'(16'd0 - mag);
            end else begin
              sample_d = (mag > SAT_MAX) ? SAT_MAX : mag;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= P_X2;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    x2_q     <= x2_d;
    amp_q    <= amp_d;
    a_q      <= a_d;
    b_q      <= b_d;
    p_q      <= p_d;
    neg_q    <= neg_d;
    sample_q <= sample_d;
  end

  assign done_o   = done_q;
  assign sample_o = sample_q;

endmodule

[rtl/csrg_engine.sv]
`timescale 1ns / 1ps
module csrg_engine #(
  parameter int MAX_LENGTH      = 65536,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csrg_pkg::csrg_cfg_t    cfg_i,
  input  logic                   in_empty_i,
  input  logic                   in_restart_i,
  output logic                   in_pop_o,
  input  logic                   out_full_i,
  output logic                   out_push_o,
  output csrg_pkg::csrg_result_t out_data_o
);

  import csrg_pkg::*;

  localparam int CNT_W = $clog2(MAX_LENGTH);
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int CMP_W = ((LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W) + 1;

  typedef enum logic [2:0] {E_IDLE, E_EVAL, E_PHASE, E_WAIT, E_DONE} state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PHASE_W-1:0] phase_q, phase_d, step_q, step_d;
  logic [AMP_W-1:0]   amp_q, amp_d;

  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                fin_q, fin_d;
  logic [SAMPLE_W-1:0] val_q, val_d;

  logic [CMP_W-1:0]        len_raw, len_eff, idx_ext, idx_out;
  logic                    sound, fin;
  logic [AMP_W-1:0]        amp_load;
  logic signed [AMP_W+2:0] amp_sum;
  logic [AMP_W-1:0]        amp_next;

  logic                       sine_start, sine_done;
  logic signed [SAMPLE_W-1:0] sine_sample;

  csrg_sine #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sine_start),
    .idx_i   (phase_q[PHASE_W-1 -: SINE_TABLE_BITS]),
    .amp_i   (amp_q),
    .done_o  (sine_done),
    .sample_o(sine_sample)
  );

  // Length zero acts as one, lengths past the limit saturate.
  assign len_raw = CMP_W'(cfg_i.paxel_length);
  assign len_eff = (len_raw == '0) ? CMP_W'(1) :
                   (len_raw > CMP_W'(MAX_LENGTH)) ? CMP_W'(MAX_LENGTH) : len_raw;
  assign idx_ext = CMP_W'(cnt_q);
  assign sound   = (idx_ext >= CMP_W'(cfg_i.first_sample)) &&
                   (idx_ext <= CMP_W'(cfg_i.last_sample)) && (idx_ext < len_eff);
  assign fin     = (CMP_W'(idx_ext + 1'b1) >= len_eff);

  assign amp_load = (cfg_i.amplitude_start > ONE_Q30) ? ONE_Q30 : cfg_i.amplitude_start;
  assign amp_sum  = $signed({3'b000, amp_q}) +
                    $signed({{2{cfg_i.amplitude_step[ASTEP_W-1]}}, cfg_i.amplitude_step});
  assign amp_next = (amp_sum < 0) ? '0 :
                    (amp_sum > $signed({3'b000, ONE_Q30})) ? ONE_Q30 : amp_sum[AMP_W-1:0];

  assign in_pop_o   = (state_q == E_IDLE) && !in_empty_i && !out_full_i;
  assign out_push_o = (state_q == E_DONE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    step_d     = step_q;
    amp_d      = amp_q;
    idx_d      = idx_q;
    fin_d      = fin_q;
    val_d      = val_q;
    sine_start = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (in_pop_o) begin
          if (in_restart_i) begin
            cnt_d   = '0;
            phase_d = cfg_i.phase_start;
            step_d  = cfg_i.phase_step_start;
            amp_d   = amp_load;
          end
          state_d = E_EVAL;
        end
      end
      E_EVAL: begin
        idx_d = cnt_q;
        fin_d = fin;
        if (sound) begin
          sine_start = 1'b1;
          step_d     = step_q + cfg_i.phase_step_slope;
          amp_d      = amp_next;
          state_d    = E_PHASE;
        end else begin
          val_d   = '0;
          state_d = E_DONE;
        end
      end
      E_PHASE: begin
        phase_d = phase_q + step_q;
        state_d = E_WAIT;
      end
      E_WAIT: begin
        if (sine_done) begin
          val_d   = sine_sample;
          state_d = E_DONE;
        end
      end
      E_DONE: begin
        if (fin_q) begin
          cnt_d   = '0;
          phase_d = cfg_i.phase_start;
          step_d  = cfg_i.phase_step_start;
          amp_d   = amp_load;
        end else begin
          cnt_d = CNT_W'(cnt_q + 1'b1);
        end
        state_d = E_IDLE;
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      cnt_q   <= '0;
      phase_q <= '0;
      step_q  <= '0;
      amp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      amp_q   <= amp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    fin_q <= fin_d;
    val_q <= val_d;
  end

  assign idx_out                 = CMP_W'(idx_q);
  assign out_data_o.sample_value = val_q;
  assign out_data_o.sample_index = idx_out[IDX_W-1:0];
  assign out_data_o.last         = fin_q;

endmodule

[rtl/chirp_sine_ramp_generator_core.sv]
`timescale 1ns / 1ps
// Flow: a tick leaves the input queue and the engine evaluates it; a sounding sample
//   forms seven products on one shared 31x31 multiplier, a silent one skips it.
// The engine takes a new tick only after its last sample went to the result queue,
//   so it works on one sample at a time.
// Reset: asynchronous, active low; clears queues, oscillator state and registers
//   (paxel_length resets to 1, all others to 0).
module chirp_sine_ramp_generator_core #(
  parameter int MAX_LENGTH      = 65536,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [csrg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csrg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample ticks
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 restart_i,
  // samples
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [csrg_pkg::SAMPLE_W-1:0] sample_value_o,
  output logic [csrg_pkg::IDX_W-1:0]           sample_index_o,
  output logic                                 last_o
);

  import csrg_pkg::*;

  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 2;

  // Register values after reset: paxel_length is one, everything else zero.
  localparam csrg_cfg_t CFG_RESET = '{paxel_length: LEN_RESET, default: '0};

  csrg_cfg_t    cfg_q, cfg_d;
  logic         cfg_we;

  logic         in_empty, in_restart, eng_pop;
  logic         out_full, eng_push;
  csrg_result_t eng_data, out_data;

  // Registers accept a transfer in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (csrg_reg_e'(cfg_index_i))
        REG_PHASE_START:      cfg_d.phase_start      = cfg_data_i[PHASE_W-1:0];
        REG_PHASE_STEP_START: cfg_d.phase_step_start = cfg_data_i[PHASE_W-1:0];
        REG_PHASE_STEP_SLOPE: cfg_d.phase_step_slope = cfg_data_i[PHASE_W-1:0];
        REG_AMPLITUDE_START:  cfg_d.amplitude_start  = cfg_data_i[AMP_W-1:0];
        REG_AMPLITUDE_STEP:   cfg_d.amplitude_step   = cfg_data_i[ASTEP_W-1:0];
        REG_FIRST_SAMPLE:     cfg_d.first_sample     = cfg_data_i[IDX_W-1:0];
        REG_LAST_SAMPLE:      cfg_d.last_sample      = cfg_data_i[IDX_W-1:0];
        REG_PAXEL_LENGTH:     cfg_d.paxel_length     = cfg_data_i[LEN_REG_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: hold incoming ticks until the engine is free.
  csrg_fifo #(
    .WIDTH(1),
    .DEPTH(IN_DEPTH)
  ) u_in_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(restart_i),
    .full_o (full),
    .pop_i  (eng_pop),
    .rdata_o(in_restart),
    .empty_o(in_empty)
  );

  // Back: one tick at a time; the engine only takes a tick when the
  // result queue has room, so every finished sample can be pushed at once.
  csrg_engine #(
    .MAX_LENGTH     (MAX_LENGTH),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_empty_i  (in_empty),
    .in_restart_i(in_restart),
    .in_pop_o    (eng_pop),
    .out_full_i  (out_full),
    .out_push_o  (eng_push),
    .out_data_o  (eng_data)
  );

  // Result queue: hold finished samples while the consumer stalls.
  csrg_fifo #(
    .WIDTH($bits(csrg_result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (eng_push),
    .wdata_i(eng_data),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_data),
    .empty_o(empty)
  );

  assign sample_value_o = out_data.sample_value;
  assign sample_index_o = out_data.sample_index;
  assign last_o         = out_data.last;

  // A finished sample never meets a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) eng_push |-> !out_full)
    else $error("result queue full on engine push");

  // The engine takes ticks one at a time, never in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) eng_pop |=> !eng_pop)
    else $error("engine took two ticks back to back");

  // After a push the result queue is not empty in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) eng_push |=> !empty)
    else $error("pushed sample missing from result queue");

endmodule
